### rtl/mksm_pkg.sv
// ----------------------------------------------------------------------------
// mksm_pkg
// Shared types, codes and field widths of the multi-keyword substring matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mksm_pkg;

    // default sizing
    localparam int NUM_KEYWORDS_DEF = 8;
    localparam int MAX_KEY_LEN_DEF  = 16;
    localparam int POS_BITS_DEF     = 16;

    // input item fields
    localparam int OP_W        = 2;
    localparam int KEY_SLOT_W  = 3;
    localparam int KEY_OFS_W   = 4;
    localparam int KEY_LEN_W   = 5;
    localparam int BYTE_W      = 8;

    // result item fields
    localparam int MATCH_SLOT_W  = 3;
    localparam int MATCH_START_W = 16;

    // stream data widths, whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_BYTE = 2'd0,
        OP_KEY_LEN  = 2'd1,
        OP_TEXT     = 2'd2,
        OP_EOL      = 2'd3
    } op_t;

endpackage

`default_nettype wire

### rtl/multi_keyword_substring_matcher_top.sv
// ----------------------------------------------------------------------------
// multi_keyword_substring_matcher_top
// Keyword table with a sliding text window; every keyword is compared against
// the window tail on each text byte and each hit is sent as one result.
// ----------------------------------------------------------------------------
// results of a text byte go to the pending vector, then to the output register
// throughput: one input transfer per cycle while no hits pend; a byte with hits
//   holds input till its last result loads; one result leaves per ready cycle
// all keywords are compared in the accept cycle; hits drain lowest slot first
// reset (aresetn low, synchronous): lengths, window, position and stop flag
//   cleared, pending hits and output dropped; keyword bytes keep their value
`default_nettype none

module multi_keyword_substring_matcher_top #(
    parameter int NUM_KEYWORDS = mksm_pkg::NUM_KEYWORDS_DEF,
    parameter int MAX_KEY_LEN  = mksm_pkg::MAX_KEY_LEN_DEF,
    parameter int POS_BITS     = mksm_pkg::POS_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // key_slot[2:0], key_offset[6:3], key_length[11:7], data_byte[19:12], zero
    input  wire logic [mksm_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  wire logic [mksm_pkg::OP_W-1:0]      s_tuser,

    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // match_slot[2:0], match_start[18:3], zero
    output logic [mksm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);
    localparam int IDX_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int SLOT_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

    // input fields
    mksm_pkg::op_t                    in_op;
    logic [mksm_pkg::KEY_SLOT_W-1:0]  in_slot;
    logic [mksm_pkg::KEY_OFS_W-1:0]   in_offset;
    logic [mksm_pkg::KEY_LEN_W-1:0]   in_length;
    logic [mksm_pkg::BYTE_W-1:0]      in_byte;

    assign in_op     = mksm_pkg::op_t'(s_tuser);
    assign in_slot   = s_tdata[2:0];
    assign in_offset = s_tdata[6:3];
    assign in_length = s_tdata[11:7];
    assign in_byte   = s_tdata[19:12];

    // state
    logic [mksm_pkg::BYTE_W-1:0] key_store_reg [NUM_KEYWORDS][MAX_KEY_LEN];
    logic [LEN_W-1:0]            key_len_reg   [NUM_KEYWORDS];
    logic [LEN_W-1:0]            key_len_next  [NUM_KEYWORDS];
    logic [mksm_pkg::BYTE_W-1:0] win_reg       [MAX_KEY_LEN];
    logic [mksm_pkg::BYTE_W-1:0] win_next      [MAX_KEY_LEN];
    logic [mksm_pkg::BYTE_W-1:0] win_shift     [MAX_KEY_LEN];
    logic [LEN_W-1:0]            fill_reg, fill_next, fill_shift;
    logic [POS_BITS-1:0]         pos_reg, pos_next;
    logic                        stopped_reg, stopped_next;

    logic [NUM_KEYWORDS-1:0]     pend_reg, pend_next;
    logic [POS_BITS-1:0]         pend_pos_reg, pend_pos_next;

    logic                        m_valid_reg, m_valid_next;
    logic [mksm_pkg::MATCH_SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic [mksm_pkg::MATCH_START_W-1:0] m_start_reg, m_start_next;
    logic                        m_last_reg, m_last_next;

    logic                        s_accept;
    logic                        text_hit;
    logic                        key_wr_en;
    logic                        len_wr_en;
    logic                        eol_en;
    logic [LEN_W-1:0]            len_sat;
    logic [NUM_KEYWORDS-1:0]     match_vec;
    logic [NUM_KEYWORDS-1:0]     pend_low, pend_rest;
    logic [SLOT_W-1:0]           first_slot;
    logic                        out_load;

    // decode of the accepted item
    always_comb begin
        key_wr_en = 1'b0;
        len_wr_en = 1'b0;
        eol_en    = 1'b0;
        text_hit  = 1'b0;
        unique case (in_op)
            mksm_pkg::OP_KEY_BYTE: key_wr_en = s_accept;
            mksm_pkg::OP_KEY_LEN:  len_wr_en = s_accept;
            mksm_pkg::OP_TEXT:     text_hit  = s_accept && !stopped_reg && (in_byte != '0);
            mksm_pkg::OP_EOL:      eol_en    = s_accept;
            default: ;
        endcase
    end

    assign len_sat = (32'(in_length) > MAX_KEY_LEN) ? LEN_W'(MAX_KEY_LEN) : LEN_W'(in_length);

    // window after shifting in the current byte
    always_comb begin
        win_shift[0] = in_byte;
        for (int i = 1; i < MAX_KEY_LEN; i++) begin
            win_shift[i] = win_reg[i-1];
        end
        fill_shift = (32'(fill_reg) < MAX_KEY_LEN) ? fill_reg + LEN_W'(1) : fill_reg;
    end

    // all keywords against the tail of the shifted window
    always_comb begin
        logic [LEN_W-1:0] idx;
        logic             ok;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            ok = (key_len_reg[k] != '0) && (fill_shift >= key_len_reg[k]);
            for (int j = 0; j < MAX_KEY_LEN; j++) begin
                idx = key_len_reg[k] - LEN_W'(1) - LEN_W'(j);
                if (32'(key_len_reg[k]) > j) begin
                    if (key_store_reg[k][j] != win_shift[idx[IDX_W-1:0]]) begin
                        ok = 1'b0;
                    end
                end
            end
            match_vec[k] = ok;
        end
    end

    // pending hits drain lowest slot first
    assign pend_low  = pend_reg & (~pend_reg + NUM_KEYWORDS'(1));
    assign pend_rest = pend_reg & ~pend_low;
    assign out_load  = (pend_reg != '0) && (!m_valid_reg || m_tready);

    always_comb begin
        first_slot = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (pend_reg[k]) begin
                first_slot = SLOT_W'(k);
            end
        end
    end

    assign s_tready = (pend_reg == '0) || (out_load && (pend_rest == '0));
    assign s_accept = s_tvalid && s_tready;

    // line state and length table
    always_comb begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        stopped_next = stopped_reg;
        key_len_next = key_len_reg;

        if (eol_en) begin
            for (int i = 0; i < MAX_KEY_LEN; i++) begin
                win_next[i] = '0;
            end
            fill_next    = '0;
            pos_next     = '0;
            stopped_next = 1'b0;
        end
        if (s_accept && (in_op == mksm_pkg::OP_TEXT) && !stopped_reg && (in_byte == '0)) begin
            stopped_next = 1'b1;
        end
        if (text_hit) begin
            win_next  = win_shift;
            fill_next = fill_shift;
            if (pos_reg != '1) begin
                pos_next = pos_reg + POS_BITS'(1);
            end
        end
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (len_wr_en && (32'(in_slot) == k)) begin
                key_len_next[k] = len_sat;
            end
        end
    end

    // pending vector and output register
    always_comb begin
        pend_next     = pend_reg;
        pend_pos_next = pend_pos_reg;
        m_valid_next  = m_valid_reg;
        m_slot_next   = m_slot_reg;
        m_start_next  = m_start_reg;
        m_last_next   = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_slot_next  = mksm_pkg::MATCH_SLOT_W'(first_slot);
            m_start_next = mksm_pkg::MATCH_START_W'(pend_pos_reg)
                         - mksm_pkg::MATCH_START_W'(key_len_reg[first_slot])
                         + mksm_pkg::MATCH_START_W'(1);
            m_last_next  = (pend_rest == '0);
            pend_next    = pend_rest;
        end
        if (s_accept) begin
            pend_next = text_hit ? match_vec : '0;
        end
        if (text_hit) begin
            pend_pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_KEY_LEN; i++) begin
                win_reg[i] <= '0;
            end
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                key_len_reg[k] <= '0;
            end
            fill_reg    <= '0;
            pos_reg     <= '0;
            stopped_reg <= 1'b0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            key_len_reg <= key_len_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            stopped_reg <= stopped_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_pos_reg <= pend_pos_next;
        m_slot_reg   <= m_slot_next;
        m_start_reg  <= m_start_next;
        m_last_reg   <= m_last_next;
    end

    // keyword bytes, undefined until written
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            for (int j = 0; j < MAX_KEY_LEN; j++) begin
                if (key_wr_en && (32'(in_slot) == k) && (32'(in_offset) == j)) begin
                    key_store_reg[k][j] <= in_byte;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_start_reg, m_slot_reg};

endmodule

`default_nettype wire

### rtl/mksm_checker.sv
// ----------------------------------------------------------------------------
// mksm_checker
// Port-level checks of the matcher's result channel against its input stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mksm_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mksm_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);

    // no result survives a reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input only stalls while results of an earlier byte are pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> m_tvalid)
        else $error("input stalled with no result on the way");

    // within the results of one text byte, valid does not drop after a non-last transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside a burst of results");

    // a stalled result transfer holds its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind multi_keyword_substring_matcher_top mksm_checker u_mksm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/tb_multi_keyword_substring_matcher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_keyword_substring_matcher_top
// Stream-level test of the keyword matcher: loads keyword tables, streams text
// lines through a driver queue and checks every match result against an
// in-bench model of the table, window and line position, under varying
// sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------

module tb_multi_keyword_substring_matcher_top;

    localparam int NUM_KW       = mksm_pkg::NUM_KEYWORDS_DEF;
    localparam int KEY_MAX      = mksm_pkg::MAX_KEY_LEN_DEF;
    localparam int POS_MAX      = (1 << mksm_pkg::POS_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        mksm_pkg::op_t                     op;
        logic [mksm_pkg::KEY_SLOT_W-1:0]   slot;
        logic [mksm_pkg::KEY_OFS_W-1:0]    ofs;
        logic [mksm_pkg::KEY_LEN_W-1:0]    len;
        logic [mksm_pkg::BYTE_W-1:0]       data;
    } item_t;

    typedef struct packed {
        logic [mksm_pkg::MATCH_SLOT_W-1:0]  slot;
        logic [mksm_pkg::MATCH_START_W-1:0] start;
        logic                               last;
    } hit_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mksm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [mksm_pkg::OP_W-1:0]      s_tuser  = mksm_pkg::OP_KEY_BYTE;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mksm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;

    item_t       pending_items[$];
    hit_t        expected_hits[$];
    item_t       next_item;
    int unsigned presented_cnt  = 0;
    int unsigned accepted_cnt   = 0;
    int unsigned text_cnt       = 0;
    int unsigned hit_cnt        = 0;
    int unsigned error_cnt      = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // matcher state as the bench sees it
    logic [7:0]  kw_bytes[NUM_KW][KEY_MAX];
    logic [4:0]  kw_len[NUM_KW];
    logic [7:0]  window[KEY_MAX];
    int unsigned fill;
    logic [15:0] line_pos;
    bit          stopped;

    // stimulus side view of the table, so generated text can hit keywords
    logic [7:0]  gen_bytes[NUM_KW][KEY_MAX];
    bit          gen_written[NUM_KW][KEY_MAX];
    int unsigned gen_len[NUM_KW];

    multi_keyword_substring_matcher_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // match prediction
    // ------------------------------------------------------------------------
    function automatic void clear_line_state();
        for (int i = 0; i < KEY_MAX; i++) window[i] = 8'h00;
        fill     = 0;
        line_pos = '0;
        stopped  = 1'b0;
    endfunction

    function automatic void predict_matches(item_t it);
        logic [15:0] here;
        int unsigned l;
        bit          hit;
        hit_t        h;
        int unsigned n = 0;
        case (it.op)
            mksm_pkg::OP_KEY_BYTE: begin
                kw_bytes[it.slot][it.ofs] = it.data;
            end
            mksm_pkg::OP_KEY_LEN: begin
                kw_len[it.slot] = (it.len > KEY_MAX) ? 5'(KEY_MAX) : it.len;
            end
            mksm_pkg::OP_EOL: begin
                clear_line_state();
            end
            default: begin
                if (!stopped) begin
                    if (it.data == 8'h00) begin
                        stopped = 1'b1;
                    end else begin
                        for (int i = KEY_MAX - 1; i > 0; i--) window[i] = window[i-1];
                        window[0] = it.data;
                        if (fill < KEY_MAX) fill++;
                        here = line_pos;
                        if (line_pos != 16'(POS_MAX)) line_pos++;
                        for (int k = 0; k < NUM_KW; k++) begin
                            l   = kw_len[k];
                            hit = (l != 0) && (fill >= l);
                            for (int j = 0; j < l; j++)
                                if (kw_bytes[k][j] != window[l-1-j]) hit = 1'b0;
                            if (hit) begin
                                h.slot  = k[mksm_pkg::MATCH_SLOT_W-1:0];
                                h.start = here - 16'(l - 1);
                                h.last  = 1'b0;
                                expected_hits.push_back(h);
                                n++;
                            end
                        end
                        if (n > 0) expected_hits[expected_hits.size()-1].last = 1'b1;
                    end
                end
            end
        endcase
    endfunction

    task automatic check_match();
        hit_t want;
        if (expected_hits.size() == 0) begin
            $error("unexpected match result: slot %0d start %0d last %0b",
                   m_tdata[2:0], m_tdata[18:3], m_tlast);
            error_cnt++;
        end else begin
            want = expected_hits.pop_front();
            if (m_tdata[2:0] !== want.slot) begin
                $error("match_slot: expected %0d, actual %0d", want.slot, m_tdata[2:0]);
                error_cnt++;
            end
            if (m_tdata[18:3] !== want.start) begin
                $error("match_start: expected %0d, actual %0d", want.start, m_tdata[18:3]);
                error_cnt++;
            end
            if (m_tlast !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, m_tlast);
                error_cnt++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic item_t make_item(mksm_pkg::op_t op, int unsigned slot,
                                        int unsigned ofs, int unsigned len,
                                        int unsigned data);
        item_t it;
        it.op   = op;
        it.slot = slot[mksm_pkg::KEY_SLOT_W-1:0];
        it.ofs  = ofs[mksm_pkg::KEY_OFS_W-1:0];
        it.len  = len[mksm_pkg::KEY_LEN_W-1:0];
        it.data = data[mksm_pkg::BYTE_W-1:0];
        return it;
    endfunction

    function automatic logic [7:0] alphabet_byte();
        case ($urandom_range(3))
            0:       return 8'h41;
            1:       return 8'h42;
            2:       return 8'h43;
            default: return 8'hC3;
        endcase
    endfunction

    task automatic key_byte(int unsigned slot, int unsigned ofs, logic [7:0] data);
        pending_items.push_back(make_item(mksm_pkg::OP_KEY_BYTE, slot, ofs,
                                          $urandom_range(31), data));
        gen_bytes[slot][ofs]   = data;
        gen_written[slot][ofs] = 1'b1;
    endtask

    // a slot is only enabled once every byte it covers has been written
    task automatic key_length(int unsigned slot, int unsigned len);
        int unsigned eff;
        eff = (len > KEY_MAX) ? KEY_MAX : len;
        for (int unsigned j = 0; j < eff; j++)
            if (!gen_written[slot][j]) key_byte(slot, j, alphabet_byte());
        pending_items.push_back(make_item(mksm_pkg::OP_KEY_LEN, slot, $urandom_range(15),
                                          len, $urandom_range(255)));
        gen_len[slot] = eff;
    endtask

    task automatic text_byte(logic [7:0] data);
        pending_items.push_back(make_item(mksm_pkg::OP_TEXT, $urandom_range(7),
                                          $urandom_range(15), $urandom_range(31), data));
    endtask

    task automatic end_line();
        pending_items.push_back(make_item(mksm_pkg::OP_EOL, $urandom_range(7),
                                          $urandom_range(15), $urandom_range(31),
                                          $urandom_range(255)));
    endtask

    task automatic load_keyword(int unsigned slot, int unsigned len);
        int unsigned eff;
        eff = (len > KEY_MAX) ? KEY_MAX : len;
        for (int unsigned j = 0; j < eff; j++)
            key_byte(slot, j, ($urandom_range(19) == 0) ? 8'h00 : alphabet_byte());
        key_length(slot, len);
    endtask

    task automatic random_traffic(int unsigned n);
        int unsigned r;
        int unsigned w;
        int unsigned k;
        int unsigned len;
        while (pending_items.size() < n) begin
            r = $urandom_range(99);
            if (r < 8) begin
                w = $urandom_range(99);
                if (w < 10)      len = 0;
                else if (w < 60) len = $urandom_range(4, 1);
                else if (w < 85) len = $urandom_range(16, 5);
                else             len = $urandom_range(31, 17);
                load_keyword($urandom_range(7), len);
            end else if (r < 11) begin
                key_byte($urandom_range(7), $urandom_range(15),
                         $urandom_range(1) ? alphabet_byte() : 8'($urandom_range(255)));
            end else if (r < 16) begin
                end_line();
            end else if (r < 19) begin
                text_byte(8'h00);
            end else if (r < 26) begin
                text_byte(8'($urandom_range(255, 1)));
            end else begin
                // text that carries a keyword, behind a short random prefix
                k = $urandom_range(7);
                repeat ($urandom_range(3)) text_byte(alphabet_byte());
                for (int unsigned j = 0; j < gen_len[k]; j++) text_byte(gen_bytes[k][j]);
            end
        end
    endtask

    task automatic directed_items();
        key_byte(0, 0, 8'h41);
        key_byte(0, 1, 8'h42);
        key_length(0, 2);
        key_byte(1, 0, 8'hFF);
        key_length(1, 1);
        key_byte(2, 0, 8'h42);
        key_length(2, 1);
        // zero byte inside a keyword: can never match
        key_byte(3, 0, 8'h41);
        key_byte(3, 1, 8'h00);
        key_length(3, 2);
        text_byte(8'h41);
        text_byte(8'h42);
        text_byte(8'hFF);
        text_byte(8'h41);
        text_byte(8'h41);
        text_byte(8'h00);
        text_byte(8'h41);
        end_line();
        text_byte(8'h41);
        text_byte(8'h42);
        key_length(2, 0);
        text_byte(8'h41);
        text_byte(8'h42);
        end_line();
    endtask

    task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (pending_items.size() != 0 || accepted_cnt != presented_cnt ||
               expected_hits.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // driver: new values at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || accepted_cnt == presented_cnt) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                s_tdata       <= {4'b0, next_item.data, next_item.len, next_item.ofs,
                                  next_item.slot};
                s_tuser       <= next_item.op;
                s_tvalid      <= 1'b1;
                presented_cnt <= presented_cnt + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_match();
                hit_cnt <= hit_cnt + 1;
            end
            if (s_tvalid && s_tready) begin
                predict_matches(make_item(mksm_pkg::op_t'(s_tuser), s_tdata[2:0],
                                          s_tdata[6:3], s_tdata[11:7], s_tdata[19:12]));
                accepted_cnt <= accepted_cnt + 1;
                if (mksm_pkg::op_t'(s_tuser) == mksm_pkg::OP_TEXT) text_cnt <= text_cnt + 1;
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $error("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_hits.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int k = 0; k < NUM_KW; k++) begin
            kw_len[k]  = '0;
            gen_len[k] = 0;
            for (int j = 0; j < KEY_MAX; j++) begin
                kw_bytes[k][j]    = 8'h00;
                gen_bytes[k][j]   = 8'h00;
                gen_written[k][j] = 1'b0;
            end
        end
        clear_line_state();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed_items();
        run_phase(0, 0);
        random_traffic(125);
        run_phase(0, 0);
        random_traffic(125);
        run_phase(75, 0);
        random_traffic(125);
        run_phase(0, 75);
        random_traffic(125);
        run_phase(14, 14);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d transfers (%0d text bytes) in %0d cycles",
                 accepted_cnt, text_cnt, cycle_cnt);
        $display("checked %0d match results, %0d mismatches, over four idle/stall mixes",
                 hit_cnt, error_cnt);
        if (error_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
